FILE: rtl/fft2d_pkg.sv
// Shared types, constants and twiddle generation functions for the 2D FFT block.
`default_nettype none

package fft2d_pkg;

  // Twiddle grid: 1024 points around the unit circle.
  localparam int    GRID_LOG     = 10;
  localparam int    QUARTER_LOG  = GRID_LOG - 2;
  localparam longint GRID_HALF   = 64'sd1 <<< (GRID_LOG - 1);
  localparam longint QUARTER     = 64'sd1 <<< QUARTER_LOG;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint ONE_Q30     = 64'sd1 <<< 30;

  // Width of the rounded twiddle product and of a butterfly sum.
  localparam int PROD_RND_W = 35;
  localparam int SUM_W      = PROD_RND_W + 1;

  typedef enum logic [1:0] {
    CFG_DIRECTION   = 2'd0,
    CFG_LOG2_WIDTH  = 2'd1,
    CFG_LOG2_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_GATHER,
    ENG_BFLY,
    ENG_SCATTER
  } eng_state_t;

  typedef struct packed {
    logic       start;
    logic       inverse;
    logic [2:0] log2_w;
    logic [2:0] log2_h;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd2147483647);
    lo = -SUM_W'(64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint clamp_q30(input longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  // Cosine or sine of 2*pi*r/1024 in Q2.30 from a seven-term series.
  // Term n divides by (2n-1)(2n) for cosine and by (2n)(2n+1) for sine.
  function automatic longint tw_series(input longint r, input bit want_sin);
    longint a;
    longint a2;
    longint ct;
    longint st;
    longint cs;
    longint ss;
    a  = (r * PI_Q30 * 2 + GRID_HALF) >>> GRID_LOG;
    a2 = (a * a) >>> 30;
    ct = ONE_Q30;
    st = a;
    cs = ONE_Q30;
    ss = a;
    for (int n = 1; n <= 6; n++) begin
      ct = (ct * a2) >>> 30;
      st = (st * a2) >>> 30;
      case (n)
        1: begin
          ct = ct / 64'sd2;
          st = st / 64'sd6;
        end
        2: begin
          ct = ct / 64'sd12;
          st = st / 64'sd20;
        end
        3: begin
          ct = ct / 64'sd30;
          st = st / 64'sd42;
        end
        4: begin
          ct = ct / 64'sd56;
          st = st / 64'sd72;
        end
        5: begin
          ct = ct / 64'sd90;
          st = st / 64'sd110;
        end
        default: begin
          ct = ct / 64'sd132;
          st = st / 64'sd156;
        end
      endcase
      if (n[0]) begin
        cs = cs - ct;
        ss = ss - st;
      end else begin
        cs = cs + ct;
        ss = ss + st;
      end
    end
    return want_sin ? clamp_q30(ss) : clamp_q30(cs);
  endfunction

  function automatic longint to_frac(input longint v, input int frac);
    return (v + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
  endfunction

  // Twiddle component at grid point j with frac fraction bits.
  function automatic longint tw_value(input longint j, input int frac, input bit want_sin);
    longint q;
    longint r;
    longint c;
    longint s;
    q = (j >>> QUARTER_LOG) & 3;
    r = j & (QUARTER - 1);
    if (r <= (QUARTER >>> 1)) begin
      c = tw_series(r, 1'b0);
      s = tw_series(r, 1'b1);
    end else begin
      c = tw_series(QUARTER - r, 1'b1);
      s = tw_series(QUARTER - r, 1'b0);
    end
    c = to_frac(c, frac);
    s = to_frac(s, frac);
    case (q)
      0: return want_sin ? s : c;
      1: return want_sin ? c : -s;
      2: return want_sin ? -s : -c;
      default: return want_sin ? -c : s;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fft2d_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module fft2d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/fft2d_twiddle.sv
// Twiddle ROM built at elaboration, registered read of cosine and sine.
`default_nettype none

module fft2d_twiddle #(
  parameter int MAXL = 6,
  parameter int FRAC = 16,
  localparam int TAW  = (MAXL > 1) ? MAXL - 1 : 1,
  localparam int TW_W = FRAC + 2
) (
  input  wire logic                   clk,
  input  wire logic [TAW-1:0]         addr,
  output      logic signed [TW_W-1:0] tw_re,
  output      logic signed [TW_W-1:0] tw_im
);

  import fft2d_pkg::*;

  localparam int TN = 1 << TAW;

  logic signed [TW_W-1:0] rom_re [TN];
  logic signed [TW_W-1:0] rom_im [TN];

  for (genvar g = 0; g < TN; g++) begin : g_rom
    localparam longint J  = longint'(g) <<< (GRID_LOG - MAXL);
    localparam longint CV = tw_value(J, FRAC, 1'b0);
    localparam longint SV = tw_value(J, FRAC, 1'b1);
    assign rom_re[g] = TW_W'(CV);
    assign rom_im[g] = TW_W'(SV);
  end

  always_ff @(posedge clk) begin
    tw_re <= rom_re[addr];
    tw_im <= rom_im[addr];
  end

endmodule

`default_nettype wire

FILE: rtl/fft2d_engine.sv
// Transform sequencer: gathers a line, runs radix-2 butterflies, scatters it back.
`default_nettype none

module fft2d_engine #(
  parameter int MAX_LOG2_WIDTH    = 6,
  parameter int MAX_LOG2_HEIGHT   = 6,
  parameter int TWIDDLE_FRAC_BITS = 16,
  localparam int AW = MAX_LOG2_WIDTH + MAX_LOG2_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fft2d_pkg::eng_cmd_t  cmd,
  output      fft2d_pkg::eng_stat_t stat,
  output      logic [AW-1:0]        fr_raddr,
  input  wire logic [63:0]          fr_rdata,
  output      logic                 fr_we,
  output      logic [AW-1:0]        fr_waddr,
  output      logic [63:0]          fr_wdata
);

  import fft2d_pkg::*;

  localparam int MAXL = (MAX_LOG2_WIDTH > MAX_LOG2_HEIGHT) ? MAX_LOG2_WIDTH : MAX_LOG2_HEIGHT;
  localparam int LN   = 1 << MAXL;
  localparam int CW   = MAXL + 1;
  localparam int SW   = $clog2(MAXL + 1);
  localparam int F    = TWIDDLE_FRAC_BITS;
  localparam int TW_W = F + 2;
  localparam int TAW  = (MAXL > 1) ? MAXL - 1 : 1;
  localparam int PW   = 32 + TW_W;

  eng_state_t state, state_next;

  logic            inverse;
  logic [2:0]      lw;
  logic [2:0]      lh;
  logic            pass;
  logic [MAXL-1:0] line_idx;
  logic [CW-1:0]   cnt;
  logic            gv;
  logic [MAXL-1:0] gi;
  logic [SW-1:0]   stage;
  logic [MAXL-1:0] bidx;
  logic [3:0]      step;
  logic            done;

  logic signed [31:0]         er, ei, ore, oim;
  logic signed [PW-1:0]       prod, acc;
  logic signed [PROD_RND_W-1:0] tr, ti;

  // Line buffer.
  logic            lwe;
  logic [MAXL-1:0] lwaddr;
  logic [63:0]     lwdata;
  logic [MAXL-1:0] lraddr;
  logic [63:0]     lrdata;

  fft2d_ram #(.WIDTH(64), .DEPTH(LN)) u_line (
    .clk  (clk),
    .we   (lwe),
    .waddr(lwaddr),
    .wdata(lwdata),
    .raddr(lraddr),
    .rdata(lrdata)
  );

  logic [TAW-1:0]         tw_addr;
  logic signed [TW_W-1:0] tw_re, tw_im;

  fft2d_twiddle #(.MAXL(MAXL), .FRAC(F)) u_tw (
    .clk  (clk),
    .addr (tw_addr),
    .tw_re(tw_re),
    .tw_im(tw_im)
  );

  // Pass geometry.
  logic            col_pass;
  logic [2:0]      m;
  logic [2:0]      lines_log;
  logic [CW-1:0]   n;
  logic            last_line;
  logic            last_b;
  logic [MAXL-1:0] half, k, e_idx, o_idx, rev_full, rev;

  function automatic logic [AW-1:0] addr_of(input logic [MAXL-1:0] l, input logic [MAXL-1:0] i,
                                           input logic colp, input logic [2:0] w_log);
    logic [AW-1:0] le;
    logic [AW-1:0] ie;
    le = AW'(l);
    ie = AW'(i);
    return colp ? ((ie << w_log) | le) : ((le << w_log) | ie);
  endfunction

  always_comb begin
    col_pass  = pass ^ inverse;
    m         = col_pass ? lh : lw;
    lines_log = col_pass ? lw : lh;
    n         = CW'(1) << m;
    last_line = (line_idx == MAXL'((CW'(1) << lines_log) - CW'(1)));
    half      = MAXL'(1) << (stage - SW'(1));
    k         = bidx & (half - MAXL'(1));
    e_idx     = ((bidx >> (stage - SW'(1))) << stage) | k;
    o_idx     = e_idx | half;
    last_b    = (CW'(bidx) == ((n >> 1) - CW'(1)));
    tw_addr   = TAW'(k << (MAXL - int'(stage)));
    for (int b = 0; b < MAXL; b++) begin
      rev_full[b] = gi[MAXL-1-b];
    end
    rev = rev_full >> (MAXL - int'(m));
  end

  // One shared multiplier; operands follow the butterfly step.
  logic signed [TW_W-1:0] wi;
  logic signed [TW_W-1:0] mul_a;
  logic signed [31:0]     mul_b;
  logic signed [PW:0]     diff, summ;
  logic signed [PW:0]     rnd_bias;
  logic signed [SUM_W-1:0] s_er, s_ei;

  always_comb begin
    wi       = inverse ? tw_im : -tw_im;
    rnd_bias = (PW+1)'(1) <<< (F - 1);
    mul_a    = tw_re;
    mul_b    = ore;
    case (step)
      4'd4: begin
        mul_a = wi;
        mul_b = oim;
      end
      4'd5: begin
        mul_a = tw_re;
        mul_b = oim;
      end
      4'd6: begin
        mul_a = wi;
        mul_b = ore;
      end
      default: begin
        mul_a = tw_re;
        mul_b = ore;
      end
    endcase
    diff = ((PW+1)'(acc) - (PW+1)'(prod) + rnd_bias) >>> F;
    summ = ((PW+1)'(acc) + (PW+1)'(prod) + rnd_bias) >>> F;
    s_er = SUM_W'(er);
    s_ei = SUM_W'(ei);
  end

  // Inverse scaling by the line length with a rounded shift.
  logic signed [31:0] sc_re, sc_im;
  logic signed [32:0] bias_m;

  always_comb begin
    bias_m = (m == 3'd0) ? 33'sd0 : (33'sd1 <<< (m - 3'd1));
    sc_re  = lrdata[63:32];
    sc_im  = lrdata[31:0];
    if (inverse) begin
      sc_re = 32'((33'(signed'(lrdata[63:32])) + bias_m) >>> m);
      sc_im = 32'((33'(signed'(lrdata[31:0])) + bias_m) >>> m);
    end
  end

  // Memory port control and next state.
  always_comb begin
    state_next = state;
    fr_raddr   = '0;
    fr_we      = 1'b0;
    fr_waddr   = addr_of(line_idx, gi, col_pass, lw);
    fr_wdata   = {sc_re, sc_im};
    lwe        = 1'b0;
    lwaddr     = rev;
    lwdata     = fr_rdata;
    lraddr     = e_idx;
    case (state)
      ENG_IDLE: begin
        if (cmd.start) state_next = ENG_GATHER;
      end
      ENG_GATHER: begin
        fr_raddr = addr_of(line_idx, cnt[MAXL-1:0], col_pass, lw);
        lwe      = gv;
        if (cnt == n) state_next = (m == 3'd0) ? ENG_SCATTER : ENG_BFLY;
      end
      ENG_BFLY: begin
        lraddr = (step == 4'd0) ? e_idx : o_idx;
        if (step == 4'd8) begin
          lwe    = 1'b1;
          lwaddr = e_idx;
          lwdata = {sat32(s_er + SUM_W'(tr)), sat32(s_ei + SUM_W'(ti))};
        end else if (step == 4'd9) begin
          lwe    = 1'b1;
          lwaddr = o_idx;
          lwdata = {sat32(s_er - SUM_W'(tr)), sat32(s_ei - SUM_W'(ti))};
          if (last_b && (3'(stage) == m)) state_next = ENG_SCATTER;
        end
      end
      ENG_SCATTER: begin
        lraddr = cnt[MAXL-1:0];
        fr_we  = gv;
        if (cnt == n) begin
          if (last_line && pass) state_next = ENG_IDLE;
          else state_next = ENG_GATHER;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      done  <= 1'b0;
      gv    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        ENG_IDLE: begin
          if (cmd.start) begin
            inverse  <= cmd.inverse;
            lw       <= cmd.log2_w;
            lh       <= cmd.log2_h;
            pass     <= 1'b0;
            line_idx <= '0;
            cnt      <= '0;
            gv       <= 1'b0;
          end
        end
        ENG_GATHER, ENG_SCATTER: begin
          gv  <= (cnt < n);
          gi  <= cnt[MAXL-1:0];
          cnt <= cnt + CW'(1);
          if (cnt == n) begin
            gv    <= 1'b0;
            cnt   <= '0;
            stage <= SW'(1);
            bidx  <= '0;
            step  <= '0;
            if (state == ENG_SCATTER) begin
              if (last_line) begin
                line_idx <= '0;
                if (pass) done <= 1'b1;
                pass <= 1'b1;
              end else begin
                line_idx <= line_idx + MAXL'(1);
              end
            end
          end
        end
        ENG_BFLY: begin
          step <= step + 4'd1;
          case (step)
            4'd1: begin
              er <= lrdata[63:32];
              ei <= lrdata[31:0];
            end
            4'd2: begin
              ore <= lrdata[63:32];
              oim <= lrdata[31:0];
            end
            4'd3: prod <= mul_a * mul_b;
            4'd4: begin
              acc  <= prod;
              prod <= mul_a * mul_b;
            end
            4'd5: begin
              tr   <= diff[PROD_RND_W-1:0];
              prod <= mul_a * mul_b;
            end
            4'd6: begin
              acc  <= prod;
              prod <= mul_a * mul_b;
            end
            4'd7: ti <= summ[PROD_RND_W-1:0];
            4'd9: begin
              step <= '0;
              if (last_b) begin
                bidx  <= '0;
                stage <= stage + SW'(1);
                cnt   <= '0;
                gv    <= 1'b0;
              end else begin
                bidx <= bidx + MAXL'(1);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (state != ENG_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: rtl/fft_2d_radix2_frame.sv
// Top level of the frame-based two-dimensional radix-2 FFT.
// Loads and fetches are taken one per cycle when not stalled; a fetch result is read from the
// registered frame store into the result queue. The final load starts the transform: each line
// is copied in, runs (L/2)*log2(L) butterflies, one at a time, and is copied back out.
// No beat is taken while the transform runs, nor in the cycle in which the engine reports
// completion and the frame is marked ready; configuration writes are held off in both cases.
// Synchronous reset clears frame and queue counters and flags, presets configuration, not the frame store.
`default_nettype none

module fft_2d_radix2_frame #(
  parameter int MAX_LOG2_WIDTH    = 6,
  parameter int MAX_LOG2_HEIGHT   = 6,
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input beats: a load (mode 0) or a fetch (mode 1).
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               mode,
  input  wire logic signed [31:0] real_in,
  input  wire logic signed [31:0] imag_in,
  // Result beats.
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] real_out,
  output      logic signed [31:0] imag_out,
  output      logic               last_of_frame,
  // Register writes.
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [2:0]         cfg_data
);

  import fft2d_pkg::*;

  localparam int AW = MAX_LOG2_WIDTH + MAX_LOG2_HEIGHT;
  localparam int CW = AW + 1;
  localparam logic [2:0] LW_RST = 3'((MAX_LOG2_WIDTH < 6) ? MAX_LOG2_WIDTH : 6);
  localparam logic [2:0] LH_RST = 3'((MAX_LOG2_HEIGHT < 6) ? MAX_LOG2_HEIGHT : 6);

  // Configuration registers.
  logic       direction;
  logic [2:0] log2_w;
  logic [2:0] log2_h;

  // Frame bookkeeping.
  logic [CW-1:0] load_count;
  logic [CW-1:0] fetch_count;
  logic          frame_ready;
  logic [CW-1:0] total;

  // Engine link.
  eng_cmd_t  eng_cmd;
  eng_stat_t eng_stat;
  logic [AW-1:0] eng_raddr, eng_waddr;
  logic          eng_we;
  logic [63:0]   eng_wdata;

  // Frame store ports.
  logic          fr_we;
  logic [AW-1:0] fr_waddr, fr_raddr;
  logic [63:0]   fr_wdata, fr_rdata;

  // Result queue: two entries, fed from the frame store read in the cycle after a fetch.
  logic        pending;
  logic        pend_last;
  logic [64:0] q_data [2];
  logic        q_rd, q_wr;
  logic [1:0]  q_cnt;
  logic        pop;
  logic [2:0]  occ;

  logic in_acc, is_load, is_fetch, serve, fetch_last, load_last, cfg_acc;

  // The exponent sum reaches 12, so it is formed in four bits.
  assign total = CW'(1) << (4'(log2_w) + 4'(log2_h));

  // The queue can absorb a fetch if, after this cycle's pop, fewer than two results are
  // held or in flight. The cycle in which the engine reports completion is also held off,
  // since frame_ready only rises at its end.
  assign pop       = out_valid & ~out_stall;
  assign occ       = 3'(q_cnt) + 3'(pending) - 3'(pop);
  assign in_stall  = eng_stat.busy | eng_stat.done | (occ >= 3'd2);
  assign in_acc    = in_valid & ~in_stall;
  assign is_load   = in_acc & ~mode;
  assign is_fetch  = in_acc & mode;
  assign serve     = is_fetch & frame_ready;
  assign fetch_last = (fetch_count + CW'(1)) >= total;
  assign load_last  = (load_count + CW'(1)) >= total;
  assign cfg_ready = ~eng_stat.busy & ~eng_stat.done;
  assign cfg_acc   = cfg_valid & cfg_ready;

  assign eng_cmd.start   = is_load & load_last;
  assign eng_cmd.inverse = direction;
  assign eng_cmd.log2_w  = log2_w;
  assign eng_cmd.log2_h  = log2_h;

  // The engine owns the frame store while it runs; loads and fetches use it otherwise.
  always_comb begin
    if (eng_stat.busy) begin
      fr_we    = eng_we;
      fr_waddr = eng_waddr;
      fr_wdata = eng_wdata;
      fr_raddr = eng_raddr;
    end else begin
      fr_we    = is_load;
      fr_waddr = load_count[AW-1:0];
      fr_wdata = {real_in, imag_in};
      fr_raddr = fetch_count[AW-1:0];
    end
  end

  fft2d_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_frame (
    .clk  (clk),
    .we   (fr_we),
    .waddr(fr_waddr),
    .wdata(fr_wdata),
    .raddr(fr_raddr),
    .rdata(fr_rdata)
  );

  fft2d_engine #(
    .MAX_LOG2_WIDTH   (MAX_LOG2_WIDTH),
    .MAX_LOG2_HEIGHT  (MAX_LOG2_HEIGHT),
    .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cmd     (eng_cmd),
    .stat    (eng_stat),
    .fr_raddr(eng_raddr),
    .fr_rdata(fr_rdata),
    .fr_we   (eng_we),
    .fr_waddr(eng_waddr),
    .fr_wdata(eng_wdata)
  );

  // Register writes clamp the side lengths and abandon any frame in progress.
  // An index past the register list is taken but changes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      log2_w      <= LW_RST;
      log2_h      <= LH_RST;
      load_count  <= '0;
      fetch_count <= '0;
      frame_ready <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          CFG_DIRECTION: begin
            direction   <= cfg_data[0];
            load_count  <= '0;
            fetch_count <= '0;
            frame_ready <= 1'b0;
          end
          CFG_LOG2_WIDTH: begin
            log2_w      <= (int'(cfg_data) > MAX_LOG2_WIDTH) ? 3'(MAX_LOG2_WIDTH) : cfg_data;
            load_count  <= '0;
            fetch_count <= '0;
            frame_ready <= 1'b0;
          end
          CFG_LOG2_HEIGHT: begin
            log2_h      <= (int'(cfg_data) > MAX_LOG2_HEIGHT) ? 3'(MAX_LOG2_HEIGHT) : cfg_data;
            load_count  <= '0;
            fetch_count <= '0;
            frame_ready <= 1'b0;
          end
          default: ;
        endcase
      end
      // A load drops any unfetched frame; the final one hands the frame to the engine.
      if (is_load) begin
        frame_ready <= 1'b0;
        fetch_count <= '0;
        load_count  <= load_last ? '0 : load_count + CW'(1);
      end
      if (serve) begin
        if (fetch_last) begin
          fetch_count <= '0;
          frame_ready <= 1'b0;
        end else begin
          fetch_count <= fetch_count + CW'(1);
        end
      end
      if (eng_stat.done) frame_ready <= 1'b1;
    end
  end

  // Result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      q_rd    <= 1'b0;
      q_wr    <= 1'b0;
      q_cnt   <= '0;
    end else begin
      pending <= serve;
      if (pending) q_wr <= ~q_wr;
      if (pop) q_rd <= ~q_rd;
      q_cnt <= q_cnt + 2'(pending) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    pend_last <= fetch_last;
    if (pending) q_data[q_wr] <= {pend_last, fr_rdata};
  end

  assign out_valid     = (q_cnt != 2'd0);
  assign last_of_frame = q_data[q_rd][64];
  assign real_out      = q_data[q_rd][63:32];
  assign imag_out      = q_data[q_rd][31:0];

endmodule

`default_nettype wire
